[rtl/lgb_pkg.sv]
// ----------------------------------------------------------------------------
// lgb_pkg
// Shared constants and types for the gap-buffer line editor.
// ----------------------------------------------------------------------------
package lgb_pkg;

  // Buffer sizing
  localparam int LINE_CAPACITY = 64;
  localparam int IDX_W         = $clog2(LINE_CAPACITY);
  localparam int CNT_W         = IDX_W + 1;
  localparam int TOT_W         = CNT_W + 1;

  // Keystroke codes
  localparam logic [7:0] KEY_LEFT    = 8'h3C;
  localparam logic [7:0] KEY_RIGHT   = 8'h3E;
  localparam logic [7:0] KEY_DELETE  = 8'h2D;
  localparam logic [7:0] KEY_NEWLINE = 8'h0A;
  localparam logic [7:0] PRINT_LOW   = 8'd32;
  localparam logic [7:0] PRINT_HIGH  = 8'd126;

  // Result status codes
  localparam logic [1:0] ST_CHAR  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

endpackage

[rtl/line_edit_gap_buffer_top.sv]
// Printable keys push and '-' pops the left stack from idle; '<' and '>' move the
// cursor: read from one store, then write into the other; at an edge nothing moves.
// Newline emits each character by a read state then a load state, set by the single
// registered read port of each store; the load waits while the output is held.
// Bad, full and empty-line results appear the cycle after the input beat.
// Reset clears the counts, sequencer and output valid flag; stores are not cleared.
// ----------------------------------------------------------------------------
// line_edit_gap_buffer_top
// Keystroke line editor keeping the line as two stacks around the cursor,
// with a small sequencer driving one write and one read port per store.
// ----------------------------------------------------------------------------
module line_edit_gap_buffer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_key_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic [1:0] out_status,
  output logic       out_last
);

  localparam int IW = lgb_pkg::IDX_W;
  localparam int CW = lgb_pkg::CNT_W;
  localparam int TW = lgb_pkg::TOT_W;

  // Stores
  logic [7:0] l_mem [lgb_pkg::LINE_CAPACITY];
  logic [7:0] r_mem [lgb_pkg::LINE_CAPACITY];
  logic [7:0] l_rdata_r, r_rdata_r;
  logic          l_we, r_we, l_re, r_re;
  logic [IW-1:0] l_waddr, r_waddr, l_raddr, r_raddr;
  logic [7:0]    l_wdata, r_wdata;

  // Control and datapath registers
  lgb_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] l_cnt_r, l_cnt_nxt, r_cnt_r, r_cnt_nxt;
  logic [CW-1:0] emit_idx_r, emit_idx_nxt;
  logic          mv_left_r, mv_left_nxt;
  logic          sel_left_r, sel_left_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  // Derived values
  logic          out_free, in_fire, printable, emit_last;
  logic [TW-1:0] total, r_emit_pos;
  logic [CW-1:0] l_dec, r_dec;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == lgb_pkg::S_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign total      = {1'b0, l_cnt_r} + {1'b0, r_cnt_r};
  assign l_dec      = l_cnt_r - CW'(1);
  assign r_dec      = r_cnt_r - CW'(1);
  assign r_emit_pos = total - TW'(1) - {1'b0, emit_idx_r};
  assign emit_last  = ({1'b0, emit_idx_r} + TW'(1)) == total;
  assign printable  = (in_key_byte >= lgb_pkg::PRINT_LOW) &&
                      (in_key_byte <= lgb_pkg::PRINT_HIGH);

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // Store ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (l_we) l_mem[l_waddr] <= l_wdata;
    if (l_re) l_rdata_r <= l_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) r_mem[r_waddr] <= r_wdata;
    if (r_re) r_rdata_r <= r_mem[r_raddr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lgb_pkg::S_IDLE: begin
        if (in_fire) begin
          priority if (in_key_byte == lgb_pkg::KEY_LEFT) begin
            if (l_cnt_r != '0) state_nxt = lgb_pkg::S_MOVE;
          end else if (in_key_byte == lgb_pkg::KEY_RIGHT) begin
            if (r_cnt_r != '0) state_nxt = lgb_pkg::S_MOVE;
          end else if (in_key_byte == lgb_pkg::KEY_NEWLINE) begin
            if (total != '0) state_nxt = lgb_pkg::S_EMIT_RD;
          end else begin
            state_nxt = lgb_pkg::S_IDLE;
          end
        end
      end
      lgb_pkg::S_MOVE:    state_nxt = lgb_pkg::S_IDLE;
      lgb_pkg::S_EMIT_RD: state_nxt = lgb_pkg::S_EMIT_LD;
      lgb_pkg::S_EMIT_LD: begin
        if (out_free) state_nxt = emit_last ? lgb_pkg::S_IDLE : lgb_pkg::S_EMIT_RD;
      end
      default:            state_nxt = lgb_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_re = 1'b0; l_raddr = '0;
    r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_re = 1'b0; r_raddr = '0;
    l_cnt_nxt      = l_cnt_r;
    r_cnt_nxt      = r_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    mv_left_nxt    = mv_left_r;
    sel_left_nxt   = sel_left_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      lgb_pkg::S_IDLE: begin
        if (in_fire) begin
          priority if (in_key_byte == lgb_pkg::KEY_LEFT) begin
            // pop left top, pushed right in the next cycle
            if (l_cnt_r != '0) begin
              l_cnt_nxt   = l_dec;
              l_re        = 1'b1;
              l_raddr     = l_dec[IW-1:0];
              mv_left_nxt = 1'b1;
            end
          end else if (in_key_byte == lgb_pkg::KEY_RIGHT) begin
            if (r_cnt_r != '0) begin
              r_cnt_nxt   = r_dec;
              r_re        = 1'b1;
              r_raddr     = r_dec[IW-1:0];
              mv_left_nxt = 1'b0;
            end
          end else if (in_key_byte == lgb_pkg::KEY_DELETE) begin
            if (l_cnt_r != '0) l_cnt_nxt = l_dec;
          end else if (in_key_byte == lgb_pkg::KEY_NEWLINE) begin
            if (total == '0) begin
              out_valid_nxt  = 1'b1;
              out_char_nxt   = '0;
              out_status_nxt = lgb_pkg::ST_EMPTY;
              out_last_nxt   = 1'b1;
            end else begin
              emit_idx_nxt = '0;
            end
          end else if (!printable) begin
            out_valid_nxt  = 1'b1;
            out_char_nxt   = '0;
            out_status_nxt = lgb_pkg::ST_BAD;
            out_last_nxt   = 1'b1;
          end else if (total >= TW'(lgb_pkg::LINE_CAPACITY)) begin
            out_valid_nxt  = 1'b1;
            out_char_nxt   = '0;
            out_status_nxt = lgb_pkg::ST_FULL;
            out_last_nxt   = 1'b1;
          end else begin
            // insert at cursor
            l_we      = 1'b1;
            l_waddr   = l_cnt_r[IW-1:0];
            l_wdata   = in_key_byte;
            l_cnt_nxt = l_cnt_r + CW'(1);
          end
        end
      end
      lgb_pkg::S_MOVE: begin
        if (mv_left_r) begin
          r_we      = 1'b1;
          r_waddr   = r_cnt_r[IW-1:0];
          r_wdata   = l_rdata_r;
          r_cnt_nxt = r_cnt_r + CW'(1);
        end else begin
          l_we      = 1'b1;
          l_waddr   = l_cnt_r[IW-1:0];
          l_wdata   = r_rdata_r;
          l_cnt_nxt = l_cnt_r + CW'(1);
        end
      end
      lgb_pkg::S_EMIT_RD: begin
        // left stack bottom-up, then right stack top-down
        if (emit_idx_r < l_cnt_r) begin
          l_re         = 1'b1;
          l_raddr      = emit_idx_r[IW-1:0];
          sel_left_nxt = 1'b1;
        end else begin
          r_re         = 1'b1;
          r_raddr      = r_emit_pos[IW-1:0];
          sel_left_nxt = 1'b0;
        end
      end
      lgb_pkg::S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = sel_left_r ? l_rdata_r : r_rdata_r;
          out_status_nxt = lgb_pkg::ST_CHAR;
          out_last_nxt   = emit_last;
          if (emit_last) begin
            l_cnt_nxt = '0;
            r_cnt_nxt = '0;
          end else begin
            emit_idx_nxt = emit_idx_r + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgb_pkg::S_IDLE;
      l_cnt_r     <= '0;
      r_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      l_cnt_r     <= l_cnt_nxt;
      r_cnt_r     <= r_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    emit_idx_r   <= emit_idx_nxt;
    mv_left_r    <= mv_left_nxt;
    sel_left_r   <= sel_left_nxt;
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // line never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total <= TW'(lgb_pkg::LINE_CAPACITY))
    else $error("line length above capacity");

  // input is only taken by an idle sequencer
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == lgb_pkg::S_IDLE))
    else $error("ready outside idle");

  // loading the last character of a line clears both stacks
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgb_pkg::S_EMIT_LD && out_free && emit_last)
      |=> (l_cnt_r == '0 && r_cnt_r == '0 && out_valid_r && out_last_r))
    else $error("line not cleared after emission");

  // emitted characters carry the character status
  a_emit_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgb_pkg::S_EMIT_LD && out_free)
      |=> (out_status_r == lgb_pkg::ST_CHAR))
    else $error("bad status on line character");
`endif

endmodule
